>>> rtl/lnps_pkg.sv
// ============================================================================
// lnps_pkg
// Shared types and constants for the last-note-priority note stack.
// ============================================================================
package lnps_pkg;

    // Event kinds carried on the input stream
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
    localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;

    // Reset values
    localparam logic [6:0] RESET_LOWEST_KEY  = 7'd24;
    localparam logic [6:0] RESET_HIGHEST_KEY = 7'd107;
    localparam logic [6:0] RESET_KEY         = 7'd60;
    localparam logic [6:0] RESET_STRENGTH    = 7'd100;

    // Gate action reported with each result item
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RETRIG  = 2'd1,
        ACT_LEGATO  = 2'd2,
        ACT_RELEASE = 2'd3
    } action_t;

    // Stack read address select
    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_NEXT = 2'd1,
        RD_TOP  = 2'd2
    } rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    set_strength;
        logic    clear_total;
        logic    idx_inc;
        logic    shift_wr;
        logic    dec_total;
        logic    push;
        logic    key_from_rd;
        logic    emit;
        rd_sel_t rd_sel;
        action_t action;
    } lnps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       in_range;
        logic       idx_lt_total;
        logic       next_lt_total;
        logic       match;
        logic       total_zero;
        logic       total_full;
        logic       out_free;
    } lnps_status_t;

endpackage

>>> rtl/last_note_priority_stack.sv
// ============================================================================
// last_note_priority_stack
// Monophonic last-note-priority note stack with key range registers.
// ============================================================================
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready      func, note, velocity
//  m_*       out  m_tvalid / m_tready      action, sounding_note,
//                                          sounding_velocity, held_count
//  APB       in   psel & penable & pwrite  lowest_key (0x0), highest_key (0x4)
//
//  One item at a time. The single read port of the stack memory sets the
//  pace: the search reads and then compares each entry in turn, removal
//  reads and then writes back each entry that it moves, and together these
//  visit each entry once; an item that needs no search skips both.
//  rst_n resets the count, key range and current note; the stack needs no
//  clearing. The next item is taken while a result waits in the output
//  register; a stalled output holds the sequencer only at its last step.
//
module last_note_priority_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] func, [8:2] note, [15:9] velocity
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] action, [8:2] sounding_note,
                                   // [15:9] sounding_velocity, [20:16] held_count
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lnps_pkg::*;

    logic [6:0]   lowest_key_reg;
    logic [6:0]   highest_key_reg;
    logic         cfg_wr;
    lnps_cmd_t    cmd;
    lnps_status_t status;

    // Register file: bit 2 of the address picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_key_reg  <= RESET_LOWEST_KEY;
            highest_key_reg <= RESET_HIGHEST_KEY;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                highest_key_reg <= pwdata[6:0];
            else
                lowest_key_reg <= pwdata[6:0];
        end
    end

    assign prdata = paddr[2] ? {25'd0, highest_key_reg} : {25'd0, lowest_key_reg};

    lnps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lnps_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .lowest_key  (lowest_key_reg),
        .highest_key (highest_key_reg),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> rtl/lnps_ctrl.sv
// ============================================================================
// lnps_ctrl
// Sequencer for one event: decode, linear search, shift-down removal,
// push or top-of-stack read, then hand the result to the output register.
// ============================================================================
module lnps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lnps_pkg::lnps_status_t status,
    output lnps_pkg::lnps_cmd_t    cmd
);
    import lnps_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_DECODE     = 9'b000000010,
        ST_SEARCH_RD  = 9'b000000100,
        ST_SEARCH_CMP = 9'b000001000,
        ST_SHIFT_RD   = 9'b000010000,
        ST_SHIFT_WR   = 9'b000100000,
        ST_PLACE      = 9'b001000000,
        ST_TOP_WAIT   = 9'b010000000,
        ST_FINISH     = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    action_t act_reg, act_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        cmd.action = act_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                act_next   = ACT_NONE;
                state_next = ST_FINISH;
                if (status.func == FUNC_NOTE_ON)
                begin
                    if (status.in_range)
                    begin
                        cmd.set_strength = 1'b1;
                        state_next       = ST_SEARCH_RD;
                    end
                end
                else if (status.func == FUNC_NOTE_OFF)
                begin
                    if (!status.total_zero)
                        state_next = ST_SEARCH_RD;
                end
                else if (status.func == FUNC_ALL_OFF)
                begin
                    cmd.clear_total = 1'b1;
                    act_next        = ACT_RELEASE;
                end
            end
            ST_SEARCH_RD:
            begin
                cmd.rd_sel = RD_IDX;
                if (status.idx_lt_total)
                    state_next = ST_SEARCH_CMP;
                else
                    state_next = ST_PLACE;
            end
            ST_SEARCH_CMP:
            begin
                if (status.match)
                    state_next = ST_SHIFT_RD;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SEARCH_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                cmd.rd_sel = RD_NEXT;
                if (status.next_lt_total)
                    state_next = ST_SHIFT_WR;
                else
                begin
                    cmd.dec_total = 1'b1;
                    state_next    = ST_PLACE;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_PLACE:
            begin
                cmd.rd_sel = RD_TOP;
                if (status.func == FUNC_NOTE_ON)
                begin
                    act_next = ACT_RETRIG;
                    if (!status.total_full)
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                        state_next = ST_TOP_WAIT;
                end
                else if (status.total_zero)
                begin
                    act_next   = ACT_RELEASE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    act_next   = ACT_LEGATO;
                    state_next = ST_TOP_WAIT;
                end
            end
            ST_TOP_WAIT:
            begin
                cmd.key_from_rd = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            act_reg   <= ACT_NONE;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

endmodule

>>> rtl/lnps_dp.sv
// ============================================================================
// lnps_dp
// Datapath: stack memory, count and index registers, current note and
// velocity, and the output register.
// ============================================================================
module lnps_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           s_tdata,
    input  logic [6:0]            lowest_key,
    input  logic [6:0]            highest_key,
    input  lnps_pkg::lnps_cmd_t    cmd,
    output lnps_pkg::lnps_status_t status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata
);
    import lnps_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [6:0]    mem [STACK_DEPTH];
    logic [6:0]    rdata_reg;
    logic [AW-1:0] raddr;
    logic [1:0]    func_reg;
    logic [6:0]    note_reg;
    logic [6:0]    vel_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] total_reg;
    logic [6:0]    key_reg;
    logic [6:0]    strength_reg;
    logic [CW:0]   idx_plus;
    logic [CW-1:0] top_idx;
    logic          out_valid_reg;
    logic [20:0]   out_reg;

    assign idx_plus = {1'b0, idx_reg} + {{CW{1'b0}}, 1'b1};
    assign top_idx  = total_reg - {{(CW-1){1'b0}}, 1'b1};

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:  raddr = idx_reg[AW-1:0];
            RD_NEXT: raddr = idx_plus[AW-1:0];
            RD_TOP:  raddr = top_idx[AW-1:0];
            default: raddr = idx_reg[AW-1:0];
        endcase
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.shift_wr)
            mem[idx_reg[AW-1:0]] <= rdata_reg;
        else if (cmd.push)
            mem[total_reg[AW-1:0]] <= note_reg;
        rdata_reg <= mem[raddr];
    end

    // Latched event fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tdata[1:0];
            note_reg <= s_tdata[8:2];
            vel_reg  <= s_tdata[15:9];
        end
    end

    // Search index, count and current note state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            total_reg    <= '0;
            key_reg      <= RESET_KEY;
            strength_reg <= RESET_STRENGTH;
        end
        else
        begin
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.idx_inc || cmd.shift_wr)
                idx_reg <= idx_plus[CW-1:0];

            if (cmd.clear_total)
                total_reg <= '0;
            else if (cmd.dec_total)
                total_reg <= top_idx;
            else if (cmd.push)
                total_reg <= total_reg + {{(CW-1){1'b0}}, 1'b1};

            if (cmd.push)
                key_reg <= note_reg;
            else if (cmd.key_from_rd)
                key_reg <= rdata_reg;

            if (cmd.set_strength)
                strength_reg <= vel_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= {5'(total_reg), strength_reg, key_reg, cmd.action};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    // Status back to the controller
    assign status.func          = func_reg;
    assign status.in_range      = (note_reg >= lowest_key) && (note_reg <= highest_key);
    assign status.idx_lt_total  = (idx_reg < total_reg);
    assign status.next_lt_total = (idx_plus < {1'b0, total_reg});
    assign status.match         = (rdata_reg == note_reg);
    assign status.total_zero    = (total_reg == '0);
    assign status.total_full    = (total_reg == CW'(STACK_DEPTH));
    assign status.out_free      = !out_valid_reg || m_tready;

endmodule
